// File: rtl/skf_pkg.sv
package skf_pkg;

    localparam int MEAS_W = 16;
    localparam int FRAC_W = 16;
    localparam int X_W    = 32;
    localparam int P_W    = 32;
    localparam int D_W    = P_W + 1;
    localparam int G_W    = FRAC_W + 1;
    localparam int EXT_W  = X_W + 2;
    localparam int MB_W   = G_W + 1;
    localparam int PROD_W = EXT_W + MB_W;
    localparam int CFG_W  = 32;
    localparam int CFG_AW = 2;

    localparam logic [G_W-1:0] GAIN_ONE = G_W'(1) << FRAC_W;

    typedef enum logic [CFG_AW-1:0] {
        CFG_PROC_NOISE = 2'd0,
        CFG_MEAS_NOISE = 2'd1,
        CFG_INIT_EST   = 2'd2,
        CFG_INIT_COV   = 2'd3
    } cfg_idx_t;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_PRED = 8'b0000_0010,
        ST_DIVS = 8'b0000_0100,
        ST_DIVW = 8'b0000_1000,
        ST_MULX = 8'b0001_0000,
        ST_ADDX = 8'b0010_0000,
        ST_COV  = 8'b0100_0000,
        ST_OUT  = 8'b1000_0000
    } state_t;

endpackage

// File: rtl/scalar_kalman_filter_unit.sv
// Items are taken one at a time: s_tready is high only in ST_IDLE, and the
// output load stalls while an earlier result is untaken. Each item goes through
// the prediction, the 17 one-bit-per-cycle steps of the restoring gain divider,
// two passes through the shared multiplier and the output load.
// Reset (aresetn low, synchronous) restores the register defaults and loads the
// estimate and covariance from them; every configuration write reloads both.
module scalar_kalman_filter_unit
    import skf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [15:0]       s_tdata,   // [15:0] measurement
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [55:0]       m_tdata,   // [31:0] estimate, [48:32] gain, zero pad
    input  logic              cfg_we,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_W-1:0]  cfg_wdata
);

    state_t state_reg, state_next;

    logic [P_W-1:0]          proc_noise_reg, proc_noise_next;
    logic [P_W-1:0]          meas_noise_reg, meas_noise_next;
    logic [X_W-1:0]          init_est_reg, init_est_next;
    logic [P_W-1:0]          init_cov_reg, init_cov_next;
    logic signed [X_W-1:0]   est_reg, est_next;
    logic [P_W-1:0]          cov_reg, cov_next;
    logic signed [MEAS_W-1:0] meas_reg, meas_next;
    logic [P_W-1:0]          p1_reg, p1_next;
    logic signed [EXT_W-1:0] diff_reg, diff_next;
    logic [G_W-1:0]          gain_reg, gain_next;
    logic signed [X_W-1:0]   out_est_reg, out_est_next;
    logic [G_W-1:0]          out_gain_reg, out_gain_next;
    logic                    m_valid_reg, m_valid_next;

    logic [P_W:0]             p1_sum;
    logic [D_W-1:0]           denom;
    logic                     div_done;
    logic [G_W-1:0]           div_quo;
    logic signed [EXT_W-1:0]  mult_a;
    logic signed [MB_W-1:0]   mult_b;
    logic signed [PROD_W-1:0] product;
    logic signed [PROD_W-1:0] prod_shr;
    logic signed [EXT_W-1:0]  x_sum;
    logic signed [EXT_W-1:0]  x_max;
    logic signed [EXT_W-1:0]  x_min;

    assign x_max = EXT_W'({1'b0, {(X_W-1){1'b1}}});
    assign x_min = -x_max - EXT_W'(1);

    assign p1_sum = {1'b0, cov_reg} + {1'b0, proc_noise_reg};
    assign denom  = {1'b0, p1_reg} + {1'b0, meas_noise_reg};

    assign mult_a = (state_reg == ST_ADDX) ? EXT_W'({2'b00, p1_reg}) : diff_reg;
    assign mult_b = (state_reg == ST_ADDX) ? MB_W'({1'b0, GAIN_ONE - gain_reg})
                                           : MB_W'({1'b0, gain_reg});

    assign prod_shr = product >>> FRAC_W;
    assign x_sum    = EXT_W'(est_reg) + prod_shr[EXT_W-1:0];

    skf_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (state_reg == ST_DIVS),
        .dividend (p1_reg),
        .divisor  (denom),
        .done     (div_done),
        .quotient (div_quo)
    );

    skf_mult u_mult (
        .aclk    (aclk),
        .op_a    (mult_a),
        .op_b    (mult_b),
        .product (product)
    );

    always_comb begin
        state_next      = state_reg;
        proc_noise_next = proc_noise_reg;
        meas_noise_next = meas_noise_reg;
        init_est_next   = init_est_reg;
        init_cov_next   = init_cov_reg;
        est_next        = est_reg;
        cov_next        = cov_reg;
        meas_next       = meas_reg;
        p1_next         = p1_reg;
        diff_next       = diff_reg;
        gain_next       = gain_reg;
        out_est_next    = out_est_reg;
        out_gain_next   = out_gain_reg;
        m_valid_next    = m_valid_reg && !m_tready;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    meas_next  = s_tdata[MEAS_W-1:0];
                    state_next = ST_PRED;
                end
            end
            ST_PRED: begin
                p1_next    = p1_sum[P_W] ? {P_W{1'b1}} : p1_sum[P_W-1:0];
                diff_next  = EXT_W'($signed({meas_reg, {FRAC_W{1'b0}}}))
                             - EXT_W'(est_reg);
                state_next = ST_DIVS;
            end
            ST_DIVS: begin
                state_next = ST_DIVW;
            end
            ST_DIVW: begin
                if (div_done) begin
                    gain_next  = div_quo;
                    state_next = ST_MULX;
                end
            end
            ST_MULX: begin
                state_next = ST_ADDX;
            end
            ST_ADDX: begin
                if (x_sum > x_max) begin
                    est_next = x_max[X_W-1:0];
                end else if (x_sum < x_min) begin
                    est_next = x_min[X_W-1:0];
                end else begin
                    est_next = x_sum[X_W-1:0];
                end
                state_next = ST_COV;
            end
            ST_COV: begin
                cov_next   = product[P_W+FRAC_W-1:FRAC_W];
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    out_est_next  = est_reg;
                    out_gain_next = gain_reg;
                    m_valid_next  = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_we) begin
            unique case (cfg_addr)
                CFG_PROC_NOISE: proc_noise_next = cfg_wdata;
                CFG_MEAS_NOISE: meas_noise_next = cfg_wdata;
                CFG_INIT_EST:   init_est_next   = cfg_wdata;
                CFG_INIT_COV:   init_cov_next   = cfg_wdata;
                default:        proc_noise_next = proc_noise_reg;
            endcase
            est_next = init_est_next;
            cov_next = init_cov_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            proc_noise_reg <= 32'd655;
            meas_noise_reg <= 32'd65536;
            init_est_reg   <= 32'd0;
            init_cov_reg   <= 32'd65536;
            est_reg        <= '0;
            cov_reg        <= 32'd65536;
        end else begin
            state_reg      <= state_next;
            m_valid_reg    <= m_valid_next;
            proc_noise_reg <= proc_noise_next;
            meas_noise_reg <= meas_noise_next;
            init_est_reg   <= init_est_next;
            init_cov_reg   <= init_cov_next;
            est_reg        <= est_next;
            cov_reg        <= cov_next;
        end
        meas_reg     <= meas_next;
        p1_reg       <= p1_next;
        diff_reg     <= diff_next;
        gain_reg     <= gain_next;
        out_est_reg  <= out_est_next;
        out_gain_reg <= out_gain_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, out_gain_reg, out_est_reg};

`ifndef SYNTHESIS
    a_gain_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (out_gain_reg <= GAIN_ONE))
        else $error("gain above one");

    a_accept_pred: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_PRED))
        else $error("accepted item did not start prediction");

    a_div_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIVW))
        else $error("divider finished outside its wait state");

    a_cfg_reload: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> (est_reg == init_est_reg) && (cov_reg == init_cov_reg))
        else $error("configuration write did not reload state");
`endif

endmodule

// File: rtl/skf_divider.sv
module skf_divider
    import skf_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [P_W-1:0]   dividend,
    input  logic [D_W-1:0]   divisor,
    output logic             done,
    output logic [G_W-1:0]   quotient
);

    localparam int CNT_W = $clog2(G_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(G_W - 1);

    logic [D_W:0]     rem_reg, rem_next;
    logic [D_W-1:0]   div_reg, div_next;
    logic [G_W-1:0]   quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic             zero_reg, zero_next;
    logic [D_W:0]     trial;
    logic             fits;

    always_comb begin
        trial = (cnt_reg == '0) ? rem_reg : {rem_reg[D_W-1:0], 1'b0};
        fits  = trial >= {1'b0, div_reg};

        rem_next  = rem_reg;
        div_next  = div_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        zero_next = zero_reg;

        if (start) begin
            rem_next  = {2'b00, dividend};
            div_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
            zero_next = (divisor == '0);
        end else if (busy_reg) begin
            rem_next = fits ? (trial - {1'b0, div_reg}) : trial;
            quo_next = {quo_reg[G_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        quo_reg  <= quo_next;
        zero_reg <= zero_next;
    end

    assign done     = done_reg;
    assign quotient = zero_reg ? GAIN_ONE : quo_reg;

endmodule

// File: rtl/skf_mult.sv
module skf_mult
    import skf_pkg::*;
(
    input  logic                     aclk,
    input  logic signed [EXT_W-1:0]  op_a,
    input  logic signed [MB_W-1:0]   op_b,
    output logic signed [PROD_W-1:0] product
);

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
    end

    assign product = prod_reg;

endmodule

// File: tb/scalar_kalman_filter_unit_tb.sv
`timescale 1ns / 100ps
module scalar_kalman_filter_unit_tb
    import skf_pkg::*;
();

    localparam int RESET_CYCLES  = 7;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 30;
    localparam int HOLD_CYCLES   = 400;
    localparam int MAX_PRINTS    = 40;
    localparam int RAND_PHASES   = 10;
    localparam int PHASE_ITEMS   = 145;

    localparam logic [31:0] PROC_NOISE_RST = 32'd655;
    localparam logic [31:0] MEAS_NOISE_RST = 32'd65536;
    localparam logic [31:0] INIT_EST_RST   = 32'd0;
    localparam logic [31:0] INIT_COV_RST   = 32'd65536;
    localparam longint unsigned UNITY      = 64'd65536;

    typedef struct packed {
        logic [31:0] estimate;
        logic [16:0] gain;
    } filter_out_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;    // [15:0] measurement
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;    // [31:0] estimate, [48:32] gain, zero pad
    logic        cfg_we;
    cfg_idx_t    cfg_addr;
    logic [31:0] cfg_wdata;

    filter_out_t pending_updates[$];

    logic [31:0] proc_noise_r;
    logic [31:0] meas_noise_r;
    logic [31:0] init_est_r;
    logic [31:0] init_cov_r;
    logic [31:0] est_r;
    logic [31:0] cov_r;

    int errors = 0;
    int cycles = 0;
    bit src_gaps = 1'b0;
    bit sink_stalls = 1'b0;
    bit hold_request = 1'b0;

    scalar_kalman_filter_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic void reload_state();
        est_r = init_est_r;
        cov_r = init_cov_r;
    endfunction

    function automatic void reset_filter_state();
        proc_noise_r = PROC_NOISE_RST;
        meas_noise_r = MEAS_NOISE_RST;
        init_est_r   = INIT_EST_RST;
        init_cov_r   = INIT_COV_RST;
        reload_state();
    endfunction

    function automatic filter_out_t filter_update(input logic [15:0] meas);
        longint unsigned p1;
        longint unsigned den;
        longint unsigned g;
        longint          diff;
        longint          delta;
        longint          x;
        filter_out_t     r;
        p1 = 64'(cov_r) + 64'(proc_noise_r);
        if (p1 > 64'hFFFF_FFFF) begin
            p1 = 64'hFFFF_FFFF;
        end
        den = p1 + 64'(meas_noise_r);
        g = (den == 0) ? UNITY : (p1 << 16) / den;
        if (g > UNITY) begin
            g = UNITY;
        end
        diff  = longint'($signed(meas)) * 65536 - longint'($signed(est_r));
        // arithmetic shift rounds toward minus infinity
        delta = (diff * longint'(g)) >>> 16;
        x = longint'($signed(est_r)) + delta;
        if (x > 64'sh7FFF_FFFF) begin
            x = 64'sh7FFF_FFFF;
        end
        if (x < -64'sh8000_0000) begin
            x = -64'sh8000_0000;
        end
        est_r = 32'(x);
        cov_r = 32'((p1 * (UNITY - g)) >> 16);
        r.estimate = 32'(x);
        r.gain     = 17'(g);
        return r;
    endfunction

    function automatic logic [15:0] rand_measurement();
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'($urandom_range(0, 15));
            4: return 16'(-$urandom_range(1, 16));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rand_reg_value();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return 32'($urandom_range(0, 65536));
            3: return 32'($urandom) >> $urandom_range(0, 31);
            default: return 32'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (errors < MAX_PRINTS) begin
            $display("%0t %s: got %h, expected %h", $realtime, what, got, want);
        end
        errors++;
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        case (idx)
            CFG_PROC_NOISE: proc_noise_r = value;
            CFG_MEAS_NOISE: meas_noise_r = value;
            CFG_INIT_EST:   init_est_r   = value;
            CFG_INIT_COV:   init_cov_r   = value;
        endcase
        reload_state();
    endtask

    task automatic send_item(input logic [15:0] meas);
        s_tvalid <= 1'b1;
        s_tdata  <= meas;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_updates.push_back(filter_update(meas));
        if (src_gaps && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_updates.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic test_default_config();
        logic [15:0] samples[6] = '{16'h0000, 16'h7FFF, 16'h8000, 16'h0001,
                                    16'hFFFF, 16'h5555};
        foreach (samples[i]) begin
            send_item(samples[i]);
        end
        drain();
    endtask

    task automatic test_zero_denominator();
        write_reg(CFG_PROC_NOISE, 32'd0);
        write_reg(CFG_MEAS_NOISE, 32'd0);
        write_reg(CFG_INIT_COV, 32'd0);
        write_reg(CFG_INIT_EST, 32'h1234_5678);
        send_item(16'h7FFF);
        send_item(16'h8000);
        send_item(16'hAAAA);
        drain();
    endtask

    task automatic test_covariance_saturation();
        write_reg(CFG_PROC_NOISE, 32'hFFFF_FFFF);
        write_reg(CFG_INIT_COV, 32'hFFFF_FFFF);
        write_reg(CFG_MEAS_NOISE, 32'hFFFF_FFFF);
        send_item(16'h7FFF);
        send_item(16'h8000);
        send_item(16'h1234);
        drain();
        write_reg(CFG_MEAS_NOISE, 32'd0);
        send_item(16'h8000);
        send_item(16'h7FFF);
        drain();
    endtask

    task automatic test_estimate_extremes();
        write_reg(CFG_PROC_NOISE, 32'd0);
        write_reg(CFG_MEAS_NOISE, 32'd65536);
        write_reg(CFG_INIT_COV, 32'hFFFF_FFFF);
        write_reg(CFG_INIT_EST, 32'h7FFF_FFFF);
        send_item(16'h8000);
        send_item(16'h7FFF);
        drain();
        write_reg(CFG_INIT_EST, 32'h8000_0000);
        send_item(16'h7FFF);
        send_item(16'h8000);
        drain();
    endtask

    task automatic test_backpressure();
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
        write_reg(CFG_INIT_EST, 32'h0001_0000);
        write_reg(CFG_PROC_NOISE, PROC_NOISE_RST);
        write_reg(CFG_MEAS_NOISE, MEAS_NOISE_RST);
        write_reg(CFG_INIT_COV, INIT_COV_RST);
        for (int n = 0; n < 60; n++) begin
            if (n == 5) begin
                hold_request = 1'b1;
            end
            send_item(rand_measurement());
        end
        drain();
    endtask

    task automatic test_random_sequences();
        int first;
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            src_gaps    = (ph < RAND_PHASES - 2);
            sink_stalls = (ph < RAND_PHASES - 2);
            first = $urandom_range(0, 3);
            for (int k = 0; k < 4; k++) begin
                write_reg(cfg_idx_t'((first + k) % 4), rand_reg_value());
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_item(rand_measurement());
            end
            drain();
        end
    endtask

    initial begin : result_sink
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++) @(posedge aclk);
            end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin : result_check
        filter_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_updates.size() == 0) begin
                report_mismatch("unexpected item", 64'(m_tdata), 64'd0);
            end else begin
                want = pending_updates.pop_front();
                if (m_tdata[31:0] !== want.estimate) begin
                    report_mismatch("estimate", 64'(m_tdata[31:0]), 64'(want.estimate));
                end
                if (m_tdata[48:32] !== want.gain) begin
                    report_mismatch("gain", 64'(m_tdata[48:32]), 64'(want.gain));
                end
                if (m_tdata[55:49] !== 7'd0) begin
                    report_mismatch("pad", 64'(m_tdata[55:49]), 64'd0);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("scalar_kalman_filter_unit_tb: done, errors");
            $finish;
        end
    end

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= 16'd0;
        cfg_we    <= 1'b0;
        cfg_addr  <= CFG_PROC_NOISE;
        cfg_wdata <= 32'd0;
        reset_filter_state();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_default_config();
        test_zero_denominator();
        test_covariance_saturation();
        test_estimate_extremes();
        test_backpressure();
        test_random_sequences();
        if (errors == 0) begin
            $display("scalar_kalman_filter_unit_tb: done, clean");
        end else begin
            $display("scalar_kalman_filter_unit_tb: done, errors");
        end
        $finish;
    end

endmodule
